[design/bba_pkg.sv]
// Package for the buddy block allocator: opcodes, register indexes,
// table entry and request types. No dependencies.
`default_nettype none
package bba_pkg;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_INIT  = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	localparam logic CFG_POOL_BASE  = 1'b0;
	localparam logic CFG_POOL_BYTES = 1'b1;

	typedef struct packed {
		logic [3:0] ord;
		logic       free;
	} entry_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  tord;
		logic [31:0] rel;
		logic        init_ok;
		logic [3:0]  init_ord;
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ARD,
		S_ACHK,
		S_SPLIT,
		S_FRD,
		S_FCHK,
		S_MRD,
		S_MCHK
	} state_t;

endpackage
`default_nettype wire

[design/bba_front.sv]
// Front end: classifies an incoming request into a decoded command.
// Depends on bba_pkg.
`default_nettype none
module bba_front import bba_pkg::*; #(
	parameter int POOL_BYTES   = 4096,
	parameter int HEADER_BYTES = 16
) (
	input  logic [1:0]  opcode,
	input  logic [12:0] request_bytes,
	input  logic [31:0] release_address,
	input  logic [31:0] pool_base,
	input  logic [12:0] pool_bytes,
	output cmd_t        cmd
);

	logic [13:0] need;
	logic [13:0] need_m1;
	logic [3:0]  bitlen;
	logic [12:0] lim;
	logic [3:0]  msb;

	assign need    = {1'b0, request_bytes} + 14'(HEADER_BYTES);
	assign need_m1 = need - 14'd1;
	assign lim     = ({4'b0, pool_bytes} < 17'(POOL_BYTES)) ? pool_bytes : 13'(POOL_BYTES);

	always_comb begin
		bitlen = 4'd0;
		for (int i = 0; i < 14; i++) begin
			if (need_m1[i]) begin
				bitlen = 4'(i + 1);
			end
		end
		msb = 4'd0;
		for (int i = 0; i < 13; i++) begin
			if (lim[i]) begin
				msb = 4'(i);
			end
		end
	end

	always_comb begin
		cmd.op       = opcode;
		cmd.tord     = (bitlen > 4'd4) ? bitlen - 4'd4 : 4'd0;
		cmd.rel      = release_address - pool_base - 32'(HEADER_BYTES);
		cmd.init_ok  = (msb >= 4'd4) && ((17'd1 << msb) > 17'(HEADER_BYTES));
		cmd.init_ord = msb - 4'd4;
	end

endmodule
`default_nettype wire

[design/bba_queue.sv]
// Two-entry queue of decoded commands between front and back end.
// Depends on bba_pkg.
`default_nettype none
module bba_queue import bba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output cmd_t head
);

	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

[design/bba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bba_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[design/bba_back.sv]
// Back end: executes allocate, free and init against the block table.
// Depends on bba_pkg and bba_ram.
`default_nettype none
module bba_back import bba_pkg::*; #(
	parameter int POOL_BYTES   = 4096,
	parameter int HEADER_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        pop,
	input  logic [31:0] pool_base,
	output logic        done,
	output logic        status,
	output logic [31:0] payload_address
);

	localparam int DEPTH    = POOL_BYTES / 16;
	localparam int SW       = $clog2(DEPTH);
	localparam int POOL_ORD = $clog2(POOL_BYTES + 1) - 5;

	state_t        state_q, state_d;
	cmd_t          cmd_q;
	logic [3:0]    act_ord_q;
	logic          root_q;
	logic          rd_root_q;
	logic [SW:0]   off_q;
	logic [SW-1:0] node_q;
	logic [3:0]    ord_q;
	logic          found_q;
	logic [SW-1:0] best_q;
	logic [3:0]    bord_q;
	logic          done_q;
	logic          status_q;
	logic [31:0]   addr_q;

	entry_t        rdata;
	entry_t        ent;
	logic          we;
	logic [SW-1:0] waddr;
	entry_t        wdata;
	logic [SW-1:0] raddr;

	logic [SW:0]   pool_slots;
	logic [SW:0]   noff;
	logic          cand;
	logic          rel_ok;
	logic [SW-1:0] rel_slot;
	logic [SW-1:0] buddy;
	logic          fin;
	logic          fin_ok;
	logic [31:0]   fin_addr;

	bba_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign ent        = rd_root_q ? entry_t'{ord: act_ord_q, free: 1'b1} : rdata;
	assign pool_slots = (SW+1)'(1) << act_ord_q;
	assign noff       = off_q + ((SW+1)'(1) << ent.ord);
	assign cand       = ent.free && (ent.ord >= cmd_q.tord) && (!found_q || ent.ord < bord_q);
	assign rel_ok     = (cmd.rel[3:0] == 4'd0) && ((cmd.rel[31:4] >> act_ord_q) == 28'd0);
	assign rel_slot   = cmd_q.rel[SW+3:4];
	assign buddy      = node_q ^ (SW'(1) << ord_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						OP_ALLOC: state_d = S_ARD;
						OP_FREE:  state_d = rel_ok ? S_FRD : S_IDLE;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_ARD:  state_d = S_ACHK;
			S_ACHK: begin
				if (noff >= pool_slots) begin
					state_d = (found_q || cand) ? S_SPLIT : S_IDLE;
				end else begin
					state_d = S_ARD;
				end
			end
			S_SPLIT: state_d = (bord_q > cmd_q.tord) ? S_SPLIT : S_IDLE;
			S_FRD:   state_d = S_FCHK;
			S_FCHK: begin
				if (off_q[SW-1:0] == rel_slot) begin
					state_d = ent.free ? S_IDLE : S_MRD;
				end else begin
					state_d = (noff >= pool_slots) ? S_IDLE : S_FRD;
				end
			end
			S_MRD: state_d = (ord_q >= act_ord_q) ? S_IDLE : S_MCHK;
			S_MCHK: begin
				if (!ent.free || ent.ord != ord_q) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_MRD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		we       = 1'b0;
		waddr    = '0;
		wdata    = '0;
		raddr    = '0;
		fin      = 1'b0;
		fin_ok   = 1'b0;
		fin_addr = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					pop = 1'b1;
					case (cmd.op)
						OP_ALLOC: fin = 1'b0;
						OP_FREE:  fin = !rel_ok;
						OP_INIT: begin
							fin    = 1'b1;
							fin_ok = cmd.init_ok;
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_ARD: raddr = off_q[SW-1:0];
			S_ACHK: begin
				if (noff >= pool_slots && !(found_q || cand)) begin
					fin = 1'b1;
				end
			end
			S_SPLIT: begin
				we = 1'b1;
				if (bord_q > cmd_q.tord) begin
					waddr = best_q + (SW'(1) << (bord_q - 4'd1));
					wdata = entry_t'{ord: bord_q - 4'd1, free: 1'b1};
				end else begin
					waddr    = best_q;
					wdata    = entry_t'{ord: cmd_q.tord, free: 1'b0};
					fin      = 1'b1;
					fin_ok   = 1'b1;
					fin_addr = pool_base + 32'({best_q, 4'b0}) + 32'(HEADER_BYTES);
				end
			end
			S_FRD: raddr = off_q[SW-1:0];
			S_FCHK: begin
				if (off_q[SW-1:0] == rel_slot) begin
					if (ent.free) begin
						fin = 1'b1;
					end else begin
						we    = 1'b1;
						waddr = rel_slot;
						wdata = entry_t'{ord: ent.ord, free: 1'b1};
					end
				end else if (noff >= pool_slots) begin
					fin = 1'b1;
				end
			end
			S_MRD: begin
				raddr = buddy;
				if (ord_q >= act_ord_q) begin
					fin    = 1'b1;
					fin_ok = 1'b1;
				end
			end
			S_MCHK: begin
				if (!ent.free || ent.ord != ord_q) begin
					fin    = 1'b1;
					fin_ok = 1'b1;
				end else begin
					we    = 1'b1;
					waddr = (buddy < node_q) ? buddy : node_q;
					wdata = entry_t'{ord: ord_q + 4'd1, free: 1'b1};
				end
			end
			default: fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			act_ord_q <= 4'(POOL_ORD);
			root_q    <= 1'b1;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (we && waddr == '0) begin
				root_q <= 1'b0;
			end
			if (state_q == S_IDLE && cmd_valid && cmd.op == OP_INIT && cmd.init_ok) begin
				root_q    <= 1'b1;
				act_ord_q <= cmd.init_ord;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_root_q <= (raddr == '0) && root_q;
		if (fin) begin
			status_q <= !fin_ok;
			addr_q   <= fin_addr;
		end
		case (state_q)
			S_IDLE: begin
				cmd_q   <= cmd;
				off_q   <= '0;
				found_q <= 1'b0;
			end
			S_ACHK: begin
				if (cand) begin
					found_q <= 1'b1;
					best_q  <= off_q[SW-1:0];
					bord_q  <= ent.ord;
				end
				off_q <= noff;
			end
			S_SPLIT: bord_q <= bord_q - 4'd1;
			S_FCHK: begin
				off_q  <= noff;
				node_q <= rel_slot;
				ord_q  <= ent.ord;
			end
			S_MCHK: begin
				if (buddy < node_q) begin
					node_q <= buddy;
				end
				ord_q <= ord_q + 4'd1;
			end
			default: off_q <= off_q;
		endcase
	end

	assign done            = done_q;
	assign status          = status_q;
	assign payload_address = addr_q;

endmodule
`default_nettype wire

[design/buddy_block_allocator.sv]
// Buddy block allocator top level. Init, nop and a free with a bad release address finish
// straight from idle; allocate walks every block in the pool, then does its splits;
// free walks blocks up to the released one, then does its merges. Each table access
// goes through the single read port of the block table RAM.
// A two-entry command queue accepts requests while the back end works. Reset leaves
// the pool as one free block of POOL_BYTES rounded down; results cannot be stalled.
`default_nettype none
module buddy_block_allocator import bba_pkg::*; #(
	parameter int POOL_BYTES   = 4096,
	parameter int HEADER_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [12:0] request_bytes,
	input  logic [31:0] release_address,
	output logic        done,
	output logic        status,
	output logic [31:0] payload_address,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] pool_base_q;
	logic [12:0] pool_bytes_q;
	cmd_t        front_cmd;
	cmd_t        head;
	logic        full;
	logic        not_empty;
	logic        pop;

	assign cfg_ready = 1'b1;
	assign busy      = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= 32'd0;
			pool_bytes_q <= 13'd4096;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_POOL_BASE:  pool_base_q  <= cfg_data;
				CFG_POOL_BYTES: pool_bytes_q <= cfg_data[12:0];
				default:        pool_base_q  <= pool_base_q;
			endcase
		end
	end

	bba_front #(.POOL_BYTES(POOL_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_front (
		.opcode          (opcode),
		.request_bytes   (request_bytes),
		.release_address (release_address),
		.pool_base       (pool_base_q),
		.pool_bytes      (pool_bytes_q),
		.cmd             (front_cmd)
	);

	bba_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (start && !full),
		.push_cmd  (front_cmd),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	bba_back #(.POOL_BYTES(POOL_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (not_empty),
		.cmd             (head),
		.pop             (pop),
		.pool_base       (pool_base_q),
		.done            (done),
		.status          (status),
		.payload_address (payload_address)
	);

endmodule
`default_nettype wire
